@@ rtl/vtb_pkg.sv @@
// Shared types, constants and log10 helper functions for the value-to-bin mapper.
package vtb_pkg;

	localparam int DATA_W     = 32;
	localparam int LOG_FRAC   = 16;
	localparam int MAX_BINS   = 4096;
	localparam int BIN_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int LOG_W      = 22;
	localparam int EXT_W      = 34;
	localparam int DIFF_W     = 33;
	localparam int QUOT_BITS  = 13;
	localparam int PROD_W     = DIFF_W + BIN_W;
	localparam int SCALE_W    = 55;
	localparam int PIPE_DEPTH = 6 + LOG_FRAC + QUOT_BITS;

	localparam logic [31:0] LOG10_2_Q32 = 32'd1292913987;
	localparam logic signed [LOG_W-1:0] LOG_OFFSET = LOG_W'(6 << LOG_FRAC);

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_MODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT  = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample_value;
		logic                     sample_null;
	} sample_t;

	typedef struct packed {
		logic signed [BIN_W-1:0] bin_index;
		logic                    mapped_inside;
	} result_t;

	typedef struct packed {
		logic                    log_mode;
		logic                    clip_mode;
		logic signed [EXT_W-1:0] lo_e;
		logic signed [EXT_W-1:0] hi_e;
		logic signed [EXT_W-1:0] ll;
		logic [DIFF_W-1:0]       width;
		logic [BIN_W-1:0]        n;
		logic [BIN_W-1:0]        mid;
	} map_cfg_t;

	typedef struct packed {
		logic [30:0] y;
		logic [4:0]  m;
	} log_norm_t;

	typedef struct packed {
		logic [30:0] y;
		logic        b;
	} log_step_t;

	function automatic logic [4:0] msb_pos(input logic [30:0] r);
		logic [4:0] m;
		m = '0;
		for (int i = 0; i < 31; i++) begin
			if (r[i]) begin
				m = 5'(i);
			end
		end
		return m;
	endfunction

	// Non-positive values are taken as the smallest positive value.
	function automatic log_norm_t log_normalize(input logic signed [DATA_W-1:0] x);
		logic [30:0] r;
		log_norm_t o;
		r = (x < 32'sd1) ? 31'd1 : x[30:0];
		o.m = msb_pos(r);
		o.y = r << (5'd30 - o.m);
		return o;
	endfunction

	function automatic log_step_t log_square(input logic [30:0] y);
		logic [61:0] p;
		log_step_t o;
		p = {31'd0, y} * {31'd0, y};
		if (p[61]) begin
			o.y = p[61:31];
			o.b = 1'b1;
		end else begin
			o.y = p[60:30];
			o.b = 1'b0;
		end
		return o;
	endfunction

	function automatic logic signed [LOG_W-1:0] log_l2(input logic [4:0] m,
		input logic [LOG_FRAC-1:0] frac);
		logic [5:0] e;
		e = {1'b0, m} - 6'd16;
		return $signed({e, frac});
	endfunction

	function automatic logic signed [SCALE_W-1:0] log_scale(input logic signed [LOG_W-1:0] l2);
		return SCALE_W'(l2) * $signed({23'd0, LOG10_2_Q32});
	endfunction

endpackage

@@ rtl/vtb_cfg.sv @@
// Configuration registers and the sequential log10 unit that prepares the range limits.
module vtb_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vtb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vtb_pkg::DATA_W-1:0]     cfg_data,
	output logic                           busy,
	output vtb_pkg::map_cfg_t              map_cfg
);
	import vtb_pkg::*;

	localparam int CNT_W = $clog2(LOG_FRAC);

	typedef enum logic [2:0] {ST_IDLE, ST_NORM, ST_SQ, ST_MUL, ST_STORE, ST_FIN} state_t;

	state_t                    state_q;
	logic                      phase_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [DATA_W-1:0]  range_low_q;
	logic signed [DATA_W-1:0]  range_high_q;
	logic                      log_mode_q;
	logic                      clip_mode_q;
	logic [BIN_W-1:0]          bin_count_q;
	logic signed [LOG_W-1:0]   hl_q;
	logic signed [LOG_W-1:0]   ll_q;
	map_cfg_t                  map_cfg_q;

	logic [30:0]               y_q;
	logic [4:0]                m_q;
	logic [LOG_FRAC-1:0]       frac_q;
	logic signed [SCALE_W-1:0] prod_q;

	logic signed [DATA_W-1:0]  operand;
	log_norm_t                 nrm;
	log_step_t                 stp;
	logic signed [LOG_W-1:0]   logv;
	logic signed [EXT_W-1:0]   lo_ext;
	logic signed [EXT_W-1:0]   hi_ext;
	logic signed [EXT_W-1:0]   span;
	logic [BIN_W-1:0]          n_eff;

	always_comb begin
		operand = phase_q ? range_low_q : range_high_q;
		nrm     = log_normalize(operand);
		stp     = log_square(y_q);
		logv    = prod_q[53:32];
		lo_ext  = log_mode_q ? EXT_W'(ll_q) : EXT_W'(range_low_q);
		hi_ext  = log_mode_q ? EXT_W'(hl_q) : EXT_W'(range_high_q);
		span    = hi_ext - lo_ext;
		if (bin_count_q == '0) begin
			n_eff = BIN_W'(1);
		end else if (bin_count_q > BIN_W'(MAX_BINS)) begin
			n_eff = BIN_W'(MAX_BINS);
		end else begin
			n_eff = bin_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_NORM;
			phase_q      <= 1'b0;
			cnt_q        <= '0;
			range_low_q  <= '0;
			range_high_q <= 32'sd65536;
			log_mode_q   <= 1'b0;
			clip_mode_q  <= 1'b1;
			bin_count_q  <= BIN_W'(256);
			hl_q         <= '0;
			ll_q         <= '0;
			map_cfg_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							REG_RANGE_LOW:  range_low_q  <= cfg_data;
							REG_RANGE_HIGH: range_high_q <= cfg_data;
							REG_LOG_MODE:   log_mode_q   <= cfg_data[0];
							REG_CLIP_MODE:  clip_mode_q  <= cfg_data[0];
							REG_BIN_COUNT:  bin_count_q  <= cfg_data[BIN_W-1:0];
							default: ;
						endcase
						phase_q <= 1'b0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					cnt_q   <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(LOG_FRAC - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_STORE;
				end
				ST_STORE: begin
					if (!phase_q) begin
						hl_q <= logv;
						if (range_low_q <= 32'sd0) begin
							ll_q    <= logv - LOG_OFFSET;
							state_q <= ST_FIN;
						end else begin
							phase_q <= 1'b1;
							state_q <= ST_NORM;
						end
					end else begin
						ll_q    <= logv;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					map_cfg_q.log_mode  <= log_mode_q;
					map_cfg_q.clip_mode <= clip_mode_q;
					map_cfg_q.lo_e      <= lo_ext;
					map_cfg_q.hi_e      <= hi_ext;
					map_cfg_q.ll        <= EXT_W'(ll_q);
					map_cfg_q.width     <= span[DIFF_W-1:0];
					map_cfg_q.n         <= n_eff;
					map_cfg_q.mid       <= (n_eff - 1'b1) >> 1;
					state_q             <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_NORM) begin
			y_q    <= nrm.y;
			m_q    <= nrm.m;
			frac_q <= '0;
		end
		if (state_q == ST_SQ) begin
			y_q    <= stp.y;
			frac_q <= {frac_q[LOG_FRAC-2:0], stp.b};
		end
		if (state_q == ST_MUL) begin
			prod_q <= log_scale(log_l2(m_q, frac_q));
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign map_cfg   = map_cfg_q;

endmodule

@@ rtl/vtb_log_pipe.sv @@
// Pipelined fixed-point log10 of the sample, one squaring per stage.
module vtb_log_pipe (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  vtb_pkg::sample_t                 in_word,
	output logic                             out_valid,
	output vtb_pkg::sample_t                 out_word,
	output logic signed [vtb_pkg::LOG_W-1:0] out_log
);
	import vtb_pkg::*;

	logic                      valid_s1;
	sample_t                   word_s1;
	logic                      lp_valid_s [LOG_FRAC+1];
	sample_t                   lp_word_s  [LOG_FRAC+1];
	logic [30:0]               lp_y_s     [LOG_FRAC+1];
	logic [4:0]                lp_m_s     [LOG_FRAC+1];
	logic [LOG_FRAC-1:0]       lp_frac_s  [LOG_FRAC+1];
	logic                      valid_sm;
	sample_t                   word_sm;
	logic signed [SCALE_W-1:0] prod_sm;

	log_norm_t                 nrm;
	log_step_t                 stp [LOG_FRAC+1];

	always_comb begin
		nrm    = log_normalize(word_s1.sample_value);
		stp[0] = '0;
		for (int k = 1; k <= LOG_FRAC; k++) begin
			stp[k] = log_square(lp_y_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_sm <= 1'b0;
			for (int k = 0; k <= LOG_FRAC; k++) begin
				lp_valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s1      <= in_valid;
			lp_valid_s[0] <= valid_s1;
			for (int k = 1; k <= LOG_FRAC; k++) begin
				lp_valid_s[k] <= lp_valid_s[k-1];
			end
			valid_sm <= lp_valid_s[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		word_s1      <= in_word;
		lp_word_s[0] <= word_s1;
		lp_y_s[0]    <= nrm.y;
		lp_m_s[0]    <= nrm.m;
		lp_frac_s[0] <= '0;
		for (int k = 1; k <= LOG_FRAC; k++) begin
			lp_word_s[k] <= lp_word_s[k-1];
			lp_y_s[k]    <= stp[k].y;
			lp_m_s[k]    <= lp_m_s[k-1];
			lp_frac_s[k] <= {lp_frac_s[k-1][LOG_FRAC-2:0], stp[k].b};
		end
		word_sm <= lp_word_s[LOG_FRAC];
		prod_sm <= log_scale(log_l2(lp_m_s[LOG_FRAC], lp_frac_s[LOG_FRAC]));
	end

	assign out_valid = valid_sm;
	assign out_word  = word_sm;
	assign out_log   = prod_sm[53:32];

endmodule

@@ rtl/value_to_bin_mapper_unit.sv @@
// Top level of the value-to-bin mapper: classification, scaling and the bin divider.
//
//   channel   handshake                  payload
//   sample    start, busy                sample (sample_value, sample_null)
//   result    result_valid (strobe)      result (bin_index, mapped_inside)
//   config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// One word is taken per cycle while busy is low; each result follows its word through
// the 16 squaring stages of the log unit and the 13 stages of the restoring divider.
// After reset and after every register write, busy stays high while the limits pass
// through the sequential log10 unit: both limits when the lower limit is positive,
// else only the upper limit. Results are shown for one cycle and never stall.
module value_to_bin_mapper_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  vtb_pkg::sample_t              sample,
	output logic                          result_valid,
	output vtb_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vtb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vtb_pkg::DATA_W-1:0]    cfg_data
);
	import vtb_pkg::*;

	typedef enum logic [2:0] {CLS_REJECT, CLS_LOW, CLS_HIGH, CLS_MID, CLS_DIV} cls_t;

	map_cfg_t                map_cfg;
	logic                    lg_valid;
	sample_t                 lg_word;
	logic signed [LOG_W-1:0] lg_log;

	vtb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.busy      (busy),
		.map_cfg   (map_cfg)
	);

	vtb_log_pipe u_log (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_word   (sample),
		.out_valid (lg_valid),
		.out_word  (lg_word),
		.out_log   (lg_log)
	);

	logic                    cls_valid_s20;
	cls_t                    cls_s20;
	logic [DIFF_W-1:0]       d_s20;
	logic                    dv_valid_s [QUOT_BITS+1];
	cls_t                    dv_cls_s   [QUOT_BITS+1];
	logic [PROD_W-1:0]       dv_rem_s   [QUOT_BITS+1];
	logic [QUOT_BITS-1:0]    dv_q_s     [QUOT_BITS+1];
	logic                    res_valid_s35;
	result_t                 res_s35;

	logic signed [EXT_W-1:0] xe;
	logic signed [EXT_W-1:0] dx;
	logic                    pos;
	cls_t                    cls_c;
	logic [PROD_W-1:0]       sub_sh  [QUOT_BITS+1];
	logic                    sub_ge  [QUOT_BITS+1];
	logic [BIN_W-1:0]        nm1;
	logic [BIN_W-1:0]        qc;
	result_t                 res_c;

	always_comb begin
		pos = (lg_word.sample_value > 32'sd0);
		if (!map_cfg.log_mode) begin
			xe = EXT_W'(lg_word.sample_value);
		end else if (pos) begin
			xe = EXT_W'(lg_log);
		end else begin
			xe = map_cfg.ll;
		end
		dx = xe - map_cfg.lo_e;
		priority if (lg_word.sample_null) begin
			cls_c = CLS_REJECT;
		end else if (map_cfg.log_mode && !pos && map_cfg.clip_mode) begin
			cls_c = CLS_REJECT;
		end else if (xe < map_cfg.lo_e) begin
			cls_c = map_cfg.clip_mode ? CLS_REJECT : CLS_LOW;
		end else if (xe > map_cfg.hi_e) begin
			cls_c = map_cfg.clip_mode ? CLS_REJECT : CLS_HIGH;
		end else if (map_cfg.hi_e == map_cfg.lo_e) begin
			cls_c = CLS_MID;
		end else begin
			cls_c = CLS_DIV;
		end
	end

	always_comb begin
		sub_sh[0] = '0;
		sub_ge[0] = 1'b0;
		for (int k = 1; k <= QUOT_BITS; k++) begin
			sub_sh[k] = PROD_W'(map_cfg.width) << (QUOT_BITS - k);
			sub_ge[k] = (dv_rem_s[k-1] >= sub_sh[k]);
		end
	end

	always_comb begin
		nm1 = map_cfg.n - 1'b1;
		qc  = (dv_q_s[QUOT_BITS] > nm1) ? nm1 : dv_q_s[QUOT_BITS];
		unique case (dv_cls_s[QUOT_BITS])
			CLS_REJECT: res_c = '{bin_index: '1, mapped_inside: 1'b0};
			CLS_LOW:    res_c = '{bin_index: '0, mapped_inside: 1'b0};
			CLS_HIGH:   res_c = '{bin_index: $signed(nm1), mapped_inside: 1'b0};
			CLS_MID:    res_c = '{bin_index: $signed(map_cfg.mid), mapped_inside: 1'b1};
			CLS_DIV:    res_c = '{bin_index: $signed(qc), mapped_inside: 1'b1};
			default:    res_c = '{bin_index: '1, mapped_inside: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid_s20 <= 1'b0;
			res_valid_s35 <= 1'b0;
			for (int k = 0; k <= QUOT_BITS; k++) begin
				dv_valid_s[k] <= 1'b0;
			end
		end else begin
			cls_valid_s20 <= lg_valid;
			dv_valid_s[0] <= cls_valid_s20;
			for (int k = 1; k <= QUOT_BITS; k++) begin
				dv_valid_s[k] <= dv_valid_s[k-1];
			end
			res_valid_s35 <= dv_valid_s[QUOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		cls_s20     <= cls_c;
		d_s20       <= dx[DIFF_W-1:0];
		dv_cls_s[0] <= cls_s20;
		dv_rem_s[0] <= {{BIN_W{1'b0}}, d_s20} * {{DIFF_W{1'b0}}, map_cfg.n};
		dv_q_s[0]   <= '0;
		for (int k = 1; k <= QUOT_BITS; k++) begin
			dv_cls_s[k] <= dv_cls_s[k-1];
			dv_rem_s[k] <= sub_ge[k] ? (dv_rem_s[k-1] - sub_sh[k]) : dv_rem_s[k-1];
			dv_q_s[k]   <= {dv_q_s[k-1][QUOT_BITS-2:0], sub_ge[k]};
		end
		res_s35 <= res_c;
	end

	assign result_valid = res_valid_s35;
	assign result       = res_s35;

endmodule

@@ rtl/vtb_checker.sv @@
// Port-level checks for the value-to-bin mapper and their binding to the top level.
module vtb_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input vtb_pkg::sample_t sample,
	input logic             result_valid,
	input vtb_pkg::result_t result,
	input logic             cfg_valid,
	input logic             cfg_ready
);
	import vtb_pkg::*;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_DEPTH result_valid)
		else $error("Accepted word produced no result at the expected cycle.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, PIPE_DEPTH))
		else $error("Result appeared without a matching accepted word.");

	a_null: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && sample.sample_null |-> ##PIPE_DEPTH
		(result.bin_index == '1 && !result.mapped_inside))
		else $error("Null word did not give a rejected result.");

	a_inside_bin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.mapped_inside |-> !result.bin_index[BIN_W-1])
		else $error("Mapped result carries a negative bin.");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("Register write did not start the limit update.");

endmodule

bind value_to_bin_mapper_unit vtb_checker u_vtb_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for the value-to-bin mapper: predicts each bin and checks every result.
`timescale 1ns / 100ps

module tb;
	import vtb_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sample_t sample;
	logic result_valid;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	logic signed [31:0] m_lo;
	logic signed [31:0] m_hi;
	logic m_log;
	logic m_clip;
	logic [12:0] m_bins;

	result_t bins_due[$];
	int mismatches;
	int idle_pct;
	bit timed_out;

	value_to_bin_mapper_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint log10_q(longint raw);
		longint r;
		longint y;
		longint frac;
		longint l2;
		longint p;
		int m;
		r = (raw < 1) ? 1 : raw;
		m = 0;
		for (int i = 0; i < 31; i++) begin
			if (r[i]) begin
				m = i;
			end
		end
		y = r << (30 - m);
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >>> 30;
			frac = frac << 1;
			if (y >= 64'h8000_0000) begin
				y = y >>> 1;
				frac = frac | 1;
			end
		end
		l2 = longint'(m) * 65536 + frac - 16 * 65536;
		p = l2 * 64'sd1292913987;
		return p >>> 32;
	endfunction

	function automatic result_t map_sample(sample_t s);
		result_t o;
		longint x;
		longint lo;
		longint hi;
		longint n;
		longint hl;
		longint ll;
		longint q;
		x = s.sample_value;
		lo = m_lo;
		hi = m_hi;
		n = m_bins;
		if (n < 1) n = 1;
		if (n > MAX_BINS) n = MAX_BINS;
		o.bin_index = -13'sd1;
		o.mapped_inside = 1'b0;
		if (s.sample_null) begin
			return o;
		end
		if (m_log) begin
			hl = log10_q(hi);
			ll = (lo <= 0) ? hl - 6 * 65536 : log10_q(lo);
			if (x <= 0) begin
				if (m_clip) begin
					return o;
				end
				x = ll;
			end else begin
				x = log10_q(x);
			end
			lo = ll;
			hi = hl;
		end
		if (x < lo) begin
			o.bin_index = m_clip ? -13'sd1 : 13'sd0;
		end else if (x > hi) begin
			o.bin_index = m_clip ? -13'sd1 : 13'(n - 1);
		end else if (hi == lo) begin
			o.bin_index = 13'((n - 1) / 2);
			o.mapped_inside = 1'b1;
		end else begin
			q = ((x - lo) * n) / (hi - lo);
			if (q > n - 1) q = n - 1;
			o.bin_index = 13'(q);
			o.mapped_inside = 1'b1;
		end
		return o;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (bins_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d/%0b",
					result.bin_index, result.mapped_inside);
			end else begin
				want = bins_due.pop_front();
				if (result.bin_index !== want.bin_index
						|| result.mapped_inside !== want.mapped_inside) begin
					mismatches++;
					if (mismatches <= 10) $display("bin mismatch: expected %0d/%0b got %0d/%0b",
						want.bin_index, want.mapped_inside,
						result.bin_index, result.mapped_inside);
				end
			end
		end
	end

	task automatic send_word(logic signed [31:0] v, logic nul);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= '{sample_value: v, sample_null: nul};
		do @(posedge clk); while (busy);
		bins_due.push_back(map_sample('{sample_value: v, sample_null: nul}));
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (bins_due.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RANGE_LOW: m_lo = d;
			REG_RANGE_HIGH: m_hi = d;
			REG_LOG_MODE: m_log = d[0];
			REG_CLIP_MODE: m_clip = d[0];
			REG_BIN_COUNT: m_bins = d[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_all(logic [31:0] lo, logic [31:0] hi, logic lg, logic cl,
		logic [12:0] n);
		drain();
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_LOG_MODE, {31'd0, lg});
		write_reg(REG_CLIP_MODE, {31'd0, cl});
		write_reg(REG_BIN_COUNT, {19'd0, n});
	endtask

	task automatic test_directed();
		send_word(32'sd0, 1'b0);
		send_word(32'sd32768, 1'b0);
		send_word(32'sd65536, 1'b0);
		send_word(-32'sd1, 1'b0);
		send_word(32'sd5, 1'b1);
		set_all(32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1, 13'd4096);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sh7fff_ffff, 1'b0);
		send_word(32'sd0, 1'b0);
		set_all(32'd100, 32'd100, 1'b0, 1'b0, 13'd0);
		send_word(32'sd100, 1'b0);
		send_word(32'sd99, 1'b0);
		send_word(32'sd101, 1'b0);
		set_all(32'd500, 32'd100, 1'b0, 1'b0, 13'd8191);
		send_word(32'sd300, 1'b0);
		set_all(32'd0, 32'd1000 << 16, 1'b1, 1'b1, 13'd60);
		send_word(32'sd0, 1'b0);
		send_word(32'sd1, 1'b0);
		send_word(32'sd65536, 1'b0);
		send_word(32'sh7fff_ffff, 1'b0);
		set_all(32'd1 << 16, -32'sd5, 1'b1, 1'b0, 13'd16);
		send_word(-32'sd7, 1'b0);
		send_word(32'sd3, 1'b0);
		send_word(32'sh7fff_ffff, 1'b0);
	endtask

	task automatic random_block(int count);
		logic [31:0] a;
		logic [31:0] b;
		logic signed [31:0] v;
		a = $urandom;
		b = $urandom;
		if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) begin
			v = a; a = b; b = v;
		end
		if ($urandom_range(1)) begin
			a = $urandom_range(200000) - 20000;
			b = a + $urandom_range(3000000);
		end
		set_all(a, b, 1'($urandom_range(1)), 1'($urandom_range(1)),
			($urandom_range(5) == 0) ? 13'($urandom) : 13'($urandom_range(64, 1)));
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: v = $urandom;
				1: v = $signed(a) + $urandom_range(b - a);
				2: v = $signed(a) + ($urandom_range(2) - 1) * $urandom_range(65536);
				default: v = $signed(b) + $urandom_range(64) - 32;
			endcase
			send_word(v, $urandom_range(15) == 0);
		end
	endtask

	task automatic test_random_phases();
		int pcts[4] = '{0, 75, 0, 25};
		for (int p = 0; p < 4; p++) begin
			idle_pct = pcts[p];
			for (int k = 0; k < 10; k++) random_block(30);
		end
	endtask

	initial begin
		timed_out = 1'b0;
		#5000000;
		timed_out = 1'b1;
		$display("[value_to_bin_mapper_unit] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_pct = 0;
		m_lo = 0;
		m_hi = 65536;
		m_log = 1'b0;
		m_clip = 1'b1;
		m_bins = 13'd256;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		drain();
		if (mismatches == 0 && bins_due.size() == 0) begin
			$display("[value_to_bin_mapper_unit] OK");
		end else begin
			$display("[value_to_bin_mapper_unit] ERROR");
		end
		$finish;
	end
endmodule
